[rtl/core/efr_pkg.sv]
// shared types and constants for the escaped byte frame receiver
package efr_pkg;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] START_RESET   = 8'd126;
    localparam logic [BYTE_W-1:0] END_RESET     = 8'd127;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'd125;
    localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd64;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 2'd0,
        EV_DATA     = 2'd1,
        EV_COMPLETE = 2'd2,
        EV_OVERFLOW = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START   = 2'd0,
        CFG_END     = 2'd1,
        CFG_ESCAPE  = 2'd2,
        CFG_MAX_LEN = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] write_index;
        t_event            event_res;
    } t_result;

endpackage

[rtl/core/efr_step.sv]
// deframing state, configuration registers and per-byte decision logic
module efr_step
    import efr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_accept,
    input  logic                 i_kind,
    input  logic [BYTE_W-1:0]    i_byte,
    output t_result              o_res
);

    logic [BYTE_W-1:0] r_start_byte, r_end_byte, r_escape_byte, r_max_length;
    logic              r_in_frame, r_escape_pending, r_frame_held;
    logic [BYTE_W-1:0] r_byte_count;

    logic              n_in_frame, n_escape_pending, n_frame_held;
    logic [BYTE_W-1:0] n_byte_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_RESET;
            r_end_byte    <= END_RESET;
            r_escape_byte <= ESCAPE_RESET;
            r_max_length  <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_START:   r_start_byte  <= i_cfg_data;
                CFG_END:     r_end_byte    <= i_cfg_data;
                CFG_ESCAPE:  r_escape_byte <= i_cfg_data;
                CFG_MAX_LEN: r_max_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_in_frame       = r_in_frame;
        n_escape_pending = r_escape_pending;
        n_frame_held     = r_frame_held;
        n_byte_count     = r_byte_count;
        o_res            = '0;
        o_res.event_res  = EV_NONE;
        if (t_kind'(i_kind) == KIND_RELEASE) begin
            n_frame_held = 1'b0;
        end else if (r_frame_held) begin
            // held frame: byte dropped
        end else if (r_byte_count >= r_max_length) begin
            n_in_frame       = 1'b0;
            n_escape_pending = 1'b0;
            n_byte_count     = '0;
            o_res.event_res  = EV_OVERFLOW;
        end else if (!r_in_frame) begin
            if (i_byte == r_start_byte) begin
                n_in_frame       = 1'b1;
                n_escape_pending = 1'b0;
            end
        end else if (!r_escape_pending && i_byte == r_escape_byte) begin
            n_escape_pending = 1'b1;
        end else if (!r_escape_pending && i_byte == r_end_byte) begin
            n_in_frame         = 1'b0;
            n_frame_held       = 1'b1;
            n_byte_count       = '0;
            o_res.event_res    = EV_COMPLETE;
            o_res.frame_length = r_byte_count;
        end else begin
            n_escape_pending  = 1'b0;
            n_byte_count      = r_byte_count + 1'b1;
            o_res.event_res   = EV_DATA;
            o_res.write_index = r_byte_count;
            o_res.data_byte   = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame       <= 1'b0;
            r_escape_pending <= 1'b0;
            r_frame_held     <= 1'b0;
            r_byte_count     <= '0;
        end else if (i_accept) begin
            r_in_frame       <= n_in_frame;
            r_escape_pending <= n_escape_pending;
            r_frame_held     <= n_frame_held;
            r_byte_count     <= n_byte_count;
        end
    end

endmodule

[rtl/core/efr_out_buf.sv]
// result register with skid stage toward the output stream
module efr_out_buf
    import efr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_main_v, r_skid_v, n_main_v, n_skid_v;
    t_result r_main, r_skid, n_main, n_skid;
    logic    pop;

    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_res   = r_main;
    assign pop     = r_main_v && i_ready;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (pop) begin
            if (r_skid_v) begin
                n_main   = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_main_v = i_push;
                n_main   = i_res;
            end
        end else if (i_push) begin
            if (!r_main_v) begin
                n_main_v = 1'b1;
                n_main   = i_res;
            end else begin
                n_skid_v = 1'b1;
                n_skid   = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

[rtl/core/escaped_byte_frame_receiver.sv]
// top level of the escaped byte frame receiver
// Takes one transaction per cycle, byte or release, while the skid stage is free, and gives exactly
// one result transaction for each through a result register; a skid stage lets the input keep
// flowing for one extra transaction while the output stalls, so the rate is one item per
// clock as long as the output side takes results. Frame state updates when the input
// transaction is accepted.
module escaped_byte_frame_receiver
    import efr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // byte_value
    input  logic                 i_s_tuser,   // kind
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [23:0]          o_m_tdata,   // frame_length, data_byte, write_index
    output logic [1:0]           o_m_tuser    // event_res
);

    logic    accept;
    t_result step_res, out_res;

    assign accept = i_s_tvalid && o_s_tready;

    efr_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_kind     (i_s_tuser),
        .i_byte     (i_s_tdata),
        .o_res      (step_res)
    );

    efr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (step_res),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_res   (out_res),
        .i_ready (i_m_tready)
    );

    assign o_m_tuser = out_res.event_res;
    assign o_m_tdata = {out_res.frame_length, out_res.data_byte, out_res.write_index};

endmodule

[rtl/core/efr_checker.sv]
// port-level checks for the escaped byte frame receiver
module efr_checker
    import efr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [23:0]          o_m_tdata,
    input logic [1:0]           o_m_tuser
);

    // fields not used by the event are zero
    a_idx_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != EV_DATA) |-> (o_m_tdata[15:0] == 16'd0))
        else $error("index or data set on a non-data event");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != EV_COMPLETE) |-> (o_m_tdata[23:16] == 8'd0))
        else $error("frame length set on a non-complete event");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // input back-pressure only when a result is waiting
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no pending result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                          && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind escaped_byte_frame_receiver efr_checker u_efr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

[verif/escaped_byte_frame_receiver_tb.sv]
// testbench for the escaped byte frame receiver: directed and random frames checked against a predictor
module escaped_byte_frame_receiver_tb;
    import efr_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_WAIT  = 6;
    localparam int LONG_HOLD    = 100;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 110;
    localparam int SHOW_LIMIT   = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    t_cfg_reg             cfg_idx = CFG_START;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    t_kind                s_tuser = KIND_BYTE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic [1:0]           m_tuser;

    // predictor state and register copies
    logic [7:0] cfg_start = START_RESET;
    logic [7:0] cfg_end = END_RESET;
    logic [7:0] cfg_escape = ESCAPE_RESET;
    logic [7:0] cfg_max_len = MAX_LEN_RESET;
    logic       in_frame = 1'b0;
    logic       esc_pending = 1'b0;
    logic       frame_held = 1'b0;
    logic [7:0] byte_count = '0;

    t_result pending_results[$];

    int  mismatches = 0;
    int  cycles = 0;
    int  effective_items = 0;
    int  sent_count = 0;
    int  frames_seen = 0;
    int  overflows_seen = 0;
    int  data_seen = 0;
    int  settings_used = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  rx_mode = 0;
    int  rx_tick = 0;
    int  stall_left = 0;
    logic hold_request = 1'b0;

    escaped_byte_frame_receiver i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // one transaction in, state updated as the block does on acceptance
    function automatic t_result deframe_byte(input t_kind kind, input logic [7:0] val);
        t_result r;
        r = '0;
        r.event_res = EV_NONE;
        if (kind == KIND_RELEASE) begin
            if (frame_held) effective_items++;
            frame_held = 1'b0;
        end else if (frame_held) begin
        end else if (byte_count >= cfg_max_len) begin
            in_frame = 1'b0;
            esc_pending = 1'b0;
            byte_count = '0;
            r.event_res = EV_OVERFLOW;
            effective_items++;
        end else if (!in_frame) begin
            if (val == cfg_start) begin
                in_frame = 1'b1;
                esc_pending = 1'b0;
                effective_items++;
            end
        end else if (!esc_pending && val == cfg_escape) begin
            esc_pending = 1'b1;
            effective_items++;
        end else if (!esc_pending && val == cfg_end) begin
            r.event_res = EV_COMPLETE;
            r.frame_length = byte_count;
            in_frame = 1'b0;
            frame_held = 1'b1;
            byte_count = '0;
            effective_items++;
        end else begin
            esc_pending = 1'b0;
            r.event_res = EV_DATA;
            r.write_index = byte_count;
            r.data_byte = val;
            byte_count = byte_count + 8'd1;
            effective_items++;
        end
        return r;
    endfunction

    // receiver side: long hold on request, otherwise a per-phase stall pattern
    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_request) begin
            hold_request <= 1'b0;
            stall_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 99) >= 35);
                2: m_tready <= ((rx_tick % 7) > 1);
                default: begin
                    if ($urandom_range(0, 19) == 0) stall_left <= $urandom_range(2, 12);
                    m_tready <= 1'b1;
                end
            endcase
        end
    end

    // result checker
    always @(posedge clk) begin
        t_result want;
        logic [7:0] got_index, got_data, got_length;
        if (rst_n && m_tvalid && m_tready) begin
            got_index = m_tdata[7:0];
            got_data = m_tdata[15:8];
            got_length = m_tdata[23:16];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected result: event %0d index %0d data %0h length %0d",
                             m_tuser, got_index, got_data, got_length);
            end else begin
                want = pending_results.pop_front();
                case (want.event_res)
                    EV_DATA:     data_seen++;
                    EV_COMPLETE: frames_seen++;
                    EV_OVERFLOW: overflows_seen++;
                    default: ;
                endcase
                if (m_tuser !== want.event_res || got_index !== want.write_index ||
                    got_data !== want.data_byte || got_length !== want.frame_length) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("mismatch: expected event %0d index %0d data %0h length %0d,%s",
                                 want.event_res, want.write_index, want.data_byte,
                                 want.frame_length, " got");
                    if (mismatches <= SHOW_LIMIT)
                        $display("          actual   event %0d index %0d data %0h length %0d",
                                 m_tuser, got_index, got_data, got_length);
                end
            end
        end
    end

    task automatic send_item(input t_kind kind, input logic [7:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 5);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= val;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(deframe_byte(kind, val));
        sent_count++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_reg r, input logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_idx <= r;
        cfg_data <= v;
        @(posedge clk);
        case (r)
            CFG_START:   cfg_start = v;
            CFG_END:     cfg_end = v;
            CFG_ESCAPE:  cfg_escape = v;
            CFG_MAX_LEN: cfg_max_len = v;
            default: ;
        endcase
    endtask

    task automatic program_config(input logic [7:0] start_v, end_v, esc_v, max_v);
        settle();
        write_register(CFG_START, start_v);
        write_register(CFG_END, end_v);
        write_register(CFG_ESCAPE, esc_v);
        write_register(CFG_MAX_LEN, max_v);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] content_byte();
        case ($urandom_range(0, 19))
            0: return cfg_start;
            1: return cfg_end;
            2: return cfg_escape;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int len, input bit close, input bit release_after);
        logic [7:0] v;
        send_item(KIND_BYTE, cfg_start);
        for (int i = 0; i < len; i++) begin
            v = content_byte();
            if (v == cfg_end || v == cfg_escape) send_item(KIND_BYTE, cfg_escape);
            send_item(KIND_BYTE, v);
        end
        if (close) send_item(KIND_BYTE, cfg_end);
        if (release_after) send_item(KIND_RELEASE, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(KIND_RELEASE, 8'($urandom_range(0, 255)));
            else
                send_item(KIND_BYTE, content_byte());
        end
    endtask

    task automatic test_reset_registers();
        gaps_on = 1'b1;
        rx_mode = 1;
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_RELEASE, 8'hFF);
        send_item(KIND_BYTE, START_RESET);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, START_RESET);
        send_item(KIND_BYTE, ESCAPE_RESET);
        send_item(KIND_BYTE, END_RESET);
        send_item(KIND_BYTE, ESCAPE_RESET);
        send_item(KIND_BYTE, ESCAPE_RESET);
        send_item(KIND_BYTE, END_RESET);
        send_item(KIND_BYTE, 8'h42);
        send_item(KIND_BYTE, START_RESET);
        send_item(KIND_RELEASE, 8'h00);
        send_item(KIND_RELEASE, 8'h00);
        send_item(KIND_BYTE, START_RESET);
        send_item(KIND_BYTE, END_RESET);
        send_item(KIND_RELEASE, 8'h5A);
    endtask

    task automatic test_length_limit();
        program_config(8'h00, 8'hFF, 8'h80, 8'd1);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h05);
        send_item(KIND_BYTE, 8'h07);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_RELEASE, 8'h00);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_BYTE, 8'hAB);
        send_item(KIND_BYTE, 8'h80);
    endtask

    task automatic test_longest_frame();
        program_config(8'h02, 8'h03, 8'h10, 8'd255);
        send_frame(255, 1'b1, 1'b1);
        send_frame(254, 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        program_config(START_RESET, END_RESET, ESCAPE_RESET, MAX_LEN_RESET);
        gaps_on = 1'b0;
        rx_mode = 0;
        hold_request <= 1'b1;
        send_frame(20, 1'b1, 1'b1);
        settle();
        send_frame(10, 1'b1, 1'b1);
    endtask

    task automatic test_random_frames();
        logic [7:0] st, en, es, mx;
        int target, len;
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                st = 8'h00; en = 8'hFF; es = 8'h80; mx = 8'd1;
            end else if (p == 1) begin
                st = 8'hFF; en = 8'h00; es = 8'h7F; mx = 8'd255;
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    st = 8'($urandom_range(0, 3));
                    en = 8'($urandom_range(0, 3));
                    es = 8'($urandom_range(0, 3));
                end else begin
                    st = 8'($urandom_range(0, 255));
                    en = 8'($urandom_range(0, 255));
                    es = 8'($urandom_range(0, 255));
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: mx = 8'($urandom_range(1, 16));
                    4:          mx = 8'd1;
                    5:          mx = 8'd255;
                    default:    mx = 8'($urandom_range(1, 255));
                endcase
            end
            program_config(st, en, es, mx);
            gaps_on = (p % 3) != 0;
            rx_mode = p % 4;
            target = effective_items + PHASE_ITEMS;
            while (effective_items < target) begin
                if (cfg_max_len <= 16 || $urandom_range(0, 29) == 0)
                    len = $urandom_range(0, cfg_max_len + 1);
                else
                    len = $urandom_range(0, 12);
                case ($urandom_range(0, 19))
                    0, 1:    send_noise($urandom_range(1, 6));
                    2:       send_frame(len, 1'b0, 1'b0);
                    3:       send_frame(len, 1'b1, 1'b0);
                    4:       send_item(KIND_RELEASE, 8'($urandom_range(0, 255)));
                    default: send_frame(len, 1'b1, 1'b1);
                endcase
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_registers();
        test_length_limit();
        test_longest_frame();
        test_backpressure();
        test_random_frames();
        settle();
        if (pending_results.size() != 0) mismatches++;
        $display("sent %0d transactions under %0d register settings plus reset values",
                 sent_count, settings_used);
        $display("saw %0d stored bytes, %0d completed frames, %0d overflow aborts",
                 data_seen, frames_seen, overflows_seen);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/efr_pkg.sv
rtl/core/efr_step.sv
rtl/core/efr_out_buf.sv
rtl/core/escaped_byte_frame_receiver.sv
rtl/core/efr_checker.sv
verif/escaped_byte_frame_receiver_tb.sv
